@@ hdl/scc_pkg.sv @@
// Package for the strongly connected components unit.
// Kind codes, sizing constants and the result word type; no dependencies.
`default_nettype none
package scc_pkg;
    localparam int MAX_NODES_DEF  = 64;
    localparam int MAX_DEGREE_DEF = 8;
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;
    typedef struct packed {
        logic             overflow;
        logic             last;
        logic             comp_end;
        logic [NODE_W-1:0] comp;
        logic [NODE_W-1:0] node;
    } t_result;
endpackage
`default_nettype wire

@@ hdl/strongly_connected_components_unit.sv @@
// Top level of the strongly connected components unit.
// Graph memories, Tarjan sequencer and result queue; uses scc_pkg, scc_out_fifo.
//
// Words are taken only while the sequencer is idle and the result queue has
// drained. An add-edge word reads the list length, then writes the successor
// and the new length. A clear word, and the pass that follows reset, sweep
// the successor counts one node a cycle over all MAX_NODES nodes. A run scans
// the node numbers to pick or skip a root and returns to the root scan after
// each root; it enters each node and closes it; it reads each stored edge,
// with an extra step when the target is on the stack; per component it pops
// each member and then scans the member set up to the highest member number;
// and it finishes. Every step of the depth-first walk reads the frame memories,
// then the node memories, into registers and acts on the registered data.
// Results queue in a FIFO of MAX_NODES entries, so the output side may stall
// freely.
`default_nettype none
module strongly_connected_components_unit #(
    parameter int MAX_NODES  = scc_pkg::MAX_NODES_DEF,
    parameter int MAX_DEGREE = scc_pkg::MAX_DEGREE_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_wdata,   // node_count
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // [5:0] source_node, [11:6] target_node
    input  wire  [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [5:0] node, [11:6] component
    output logic        m_axis_tlast,  // last
    output logic [1:0]  m_axis_tuser   // [0] component_end, [1] overflow
);
    localparam int NW  = scc_pkg::NODE_W;
    localparam int CW  = scc_pkg::CNT_W;
    localparam int NA  = $clog2(MAX_NODES);
    localparam int DA  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DCW = $clog2(MAX_DEGREE + 1);
    localparam int SD  = MAX_NODES << DA;

    localparam logic [4:0] S_IDLE = 5'd0, S_CLR = 5'd1, S_ROOT = 5'd2,
        S_ENTER = 5'd3, S_TOP = 5'd4, S_TOPW = 5'd5, S_SUCC = 5'd6,
        S_SUCCW = 5'd7, S_DONE = 5'd8, S_DONEW = 5'd9, S_POP = 5'd10,
        S_POPW = 5'd11, S_EMIT = 5'd12, S_FIN = 5'd13, S_PAR = 5'd14,
        S_ADD = 5'd15, S_TOPX = 5'd16;

    // successor lists and their lengths; lengths swept by clear
    logic [NW-1:0]  r_succ [SD];
    logic [DCW-1:0] r_cnt  [MAX_NODES];
    // per-node Tarjan numbers in two memories, marks as bit vectors
    logic [CW-1:0]  r_vis  [MAX_NODES];
    logic [CW-1:0]  r_low  [MAX_NODES];
    logic [MAX_NODES-1:0] r_onst, r_seen, r_memb;
    // walk frames: node, parent, position
    logic [NW-1:0]  r_wn [MAX_NODES];
    logic [NW-1:0]  r_wp [MAX_NODES];
    logic [DCW-1:0] r_wpos [MAX_NODES];
    logic [NW-1:0]  r_nst [MAX_NODES];

    logic [4:0]  r_st;
    logic [CW-1:0] r_nc, r_n, r_idx, r_root, r_sp, r_wd, r_v;
    logic [NW-1:0] r_comp;
    logic        r_ovf, r_any;
    // registered reads
    logic [NW-1:0] r_b, r_p, r_s, r_t;
    logic [DCW-1:0] r_pos;
    logic [CW-1:0] r_lowb, r_visb, r_lowp, r_viss;
    logic [NW-1:0] r_succrd;
    logic [DCW-1:0] r_cntrd;
    // held add-edge word
    logic [NW-1:0] r_src, r_dst;

    logic acc;
    logic [1:0] kind;
    logic [NW-1:0] src, dst;
    scc_pkg::t_result res;
    logic res_push, fifo_empty;
    logic [NA-1:0] b_a, s_a;
    assign kind = s_axis_tuser;
    assign src  = s_axis_tdata[5:0];
    assign dst  = s_axis_tdata[11:6];
    // hold off new words until the previous run's results have all left
    assign s_axis_tready = (r_st == S_IDLE) && fifo_empty;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign b_a = r_b[NA-1:0];
    assign s_a = r_s[NA-1:0];

    // find next member at or after r_v (scanned one node a cycle)
    logic more_memb;
    assign more_memb = |(r_memb >> r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // sweep the successor counts before the first word
            r_st <= S_CLR; r_ovf <= 1'b0; r_nc <= scc_pkg::NODE_COUNT_RST;
            r_idx <= '0;
        end else begin
            if (i_cfg_we) r_nc <= i_cfg_wdata;
            case (r_st)
            S_IDLE: if (acc) begin
                case (kind)
                scc_pkg::KIND_ADD: if ({1'b0, src} < CW'(MAX_NODES) &&
                                       {1'b0, dst} < CW'(MAX_NODES)) begin
                    r_src <= src; r_dst <= dst;
                    r_cntrd <= r_cnt[src[NA-1:0]];
                    r_st <= S_ADD;
                end
                scc_pkg::KIND_CLEAR: begin
                    r_ovf <= 1'b0; r_idx <= '0; r_st <= S_CLR;
                end
                scc_pkg::KIND_RUN: begin
                    r_n <= (r_nc > CW'(MAX_NODES)) ? CW'(MAX_NODES) : r_nc;
                    r_onst <= '0; r_seen <= '0; r_idx <= '0; r_sp <= '0;
                    r_wd <= '0; r_comp <= '0; r_root <= '0; r_any <= 1'b0;
                    r_st <= S_ROOT;
                end
                default: ;
                endcase
            end
            S_ADD: begin
                if (r_cntrd >= DCW'(MAX_DEGREE)) r_ovf <= 1'b1;
                else begin
                    r_succ[{r_src[NA-1:0], r_cntrd[DA-1:0]}] <= r_dst;
                    r_cnt[r_src[NA-1:0]] <= r_cntrd + 1'b1;
                end
                r_st <= S_IDLE;
            end
            S_CLR: begin
                r_cnt[r_idx[NA-1:0]] <= '0;
                r_idx <= r_idx + 1'b1;
                if (r_idx == CW'(MAX_NODES - 1)) r_st <= S_IDLE;
            end
            S_ROOT: begin
                if (r_root >= r_n) r_st <= S_FIN;
                else if (r_seen[r_root[NA-1:0]]) r_root <= r_root + 1'b1;
                else begin
                    r_s <= r_root[NW-1:0]; r_b <= r_root[NW-1:0]; r_st <= S_ENTER;
                end
            end
            S_ENTER: begin
                r_wn[r_wd[NA-1:0]] <= r_s; r_wp[r_wd[NA-1:0]] <= r_b;
                r_wpos[r_wd[NA-1:0]] <= '0; r_wd <= r_wd + 1'b1;
                r_nst[r_sp[NA-1:0]] <= r_s; r_sp <= r_sp + 1'b1;
                r_vis[s_a] <= r_idx; r_low[s_a] <= r_idx;
                r_onst[s_a] <= 1'b1; r_seen[s_a] <= 1'b1;
                r_idx <= r_idx + 1'b1;
                r_st <= S_TOP;
            end
            S_TOP: begin
                if (r_wd == '0) begin
                    r_root <= r_root + 1'b1; r_st <= S_ROOT;
                end else begin
                    r_b <= r_wn[r_wd[NA-1:0] - 1'b1];
                    r_p <= r_wp[r_wd[NA-1:0] - 1'b1];
                    r_pos <= r_wpos[r_wd[NA-1:0] - 1'b1];
                    r_st <= S_TOPW;
                end
            end
            S_TOPW: begin
                r_lowb <= r_low[b_a]; r_visb <= r_vis[b_a];
                r_lowp <= r_low[r_p[NA-1:0]];
                r_cntrd <= r_cnt[b_a];
                r_st <= S_TOPX;
            end
            S_TOPX: begin
                if (r_pos >= r_cntrd) r_st <= S_DONE;
                else begin
                    r_succrd <= r_succ[{b_a, r_pos[DA-1:0]}];
                    r_wpos[r_wd[NA-1:0] - 1'b1] <= r_pos + 1'b1;
                    r_st <= S_SUCC;
                end
            end
            S_SUCC: begin
                r_s <= r_succrd;
                if ({1'b0, r_succrd} >= r_n) r_st <= S_TOP;
                else if (!r_seen[r_succrd[NA-1:0]]) r_st <= S_ENTER;
                else if (r_onst[r_succrd[NA-1:0]]) begin
                    r_viss <= r_vis[r_succrd[NA-1:0]];
                    r_st <= S_SUCCW;
                end
                else r_st <= S_TOP;
            end
            S_SUCCW: begin
                if (r_viss < r_lowb) r_low[b_a] <= r_viss;
                r_st <= S_TOP;
            end
            S_DONE: begin
                if (r_lowb == r_visb) begin
                    r_memb <= '0; r_st <= S_POP;
                end else r_st <= S_PAR;
            end
            S_POP: begin
                r_t <= r_nst[r_sp[NA-1:0] - 1'b1];
                r_sp <= r_sp - 1'b1;
                r_st <= S_POPW;
            end
            S_POPW: begin
                r_onst[r_t[NA-1:0]] <= 1'b0;
                r_memb[r_t[NA-1:0]] <= 1'b1;
                if (r_t != r_b && r_sp != '0) r_st <= S_POP;
                else begin
                    r_v <= '0; r_st <= S_EMIT;
                end
            end
            S_EMIT: begin
                if (!more_memb) begin
                    r_comp <= r_comp + 1'b1; r_st <= S_PAR;
                end else begin
                    if (r_memb[r_v[NA-1:0]]) r_any <= 1'b1;
                    r_v <= r_v + 1'b1;
                end
            end
            S_PAR: begin
                r_wd <= r_wd - 1'b1;
                if (r_lowb < r_lowp) r_low[r_p[NA-1:0]] <= r_lowb;
                r_st <= S_TOP;
            end
            S_FIN: begin
                if (res_push || !r_any) r_st <= S_IDLE;
                r_any <= 1'b0;
            end
            default: r_st <= S_IDLE;
            endcase
        end
    end

    // hold the newest result one step so the run's final word can carry last
    scc_pkg::t_result r_hold;
    logic r_hv;
    logic emit_now;
    assign emit_now = (r_st == S_EMIT) && more_memb && r_memb[r_v[NA-1:0]];
    logic end_of_comp;
    assign end_of_comp = ((r_memb >> r_v[NA-1:0]) >> 1) == '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hv <= 1'b0;
        else if (emit_now) r_hv <= 1'b1;
        else if (r_st == S_FIN) r_hv <= 1'b0;
        if (emit_now) begin
            r_hold.node <= r_v[NW-1:0];
            r_hold.comp <= r_comp;
            r_hold.comp_end <= end_of_comp;
            r_hold.last <= 1'b0;
            r_hold.overflow <= r_ovf;
        end
    end
    assign res_push = r_hv && (emit_now || r_st == S_FIN);
    always_comb begin
        res = r_hold;
        res.last = (r_st == S_FIN);
    end

    scc_pkg::t_result fo;
    scc_out_fifo #(.DEPTH(MAX_NODES)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_push), .i_data(res),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(fo),
        .o_empty(fifo_empty)
    );
    assign m_axis_tdata = {4'd0, fo.comp, fo.node};
    assign m_axis_tlast = fo.last;
    assign m_axis_tuser = {fo.overflow, fo.comp_end};
endmodule
`default_nettype wire

@@ hdl/scc_out_fifo.sv @@
// Result queue of the strongly connected components unit.
// Memory-based FIFO with a registered read stage; uses scc_pkg.
`default_nettype none
module scc_out_fifo #(
    parameter int DEPTH = scc_pkg::MAX_NODES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  scc_pkg::t_result i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output scc_pkg::t_result o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    scc_pkg::t_result r_mem [1 << AW];
    logic [AW:0] r_wp, r_rp;
    logic pop;
    logic mem_has;
    assign mem_has = (r_wp != r_rp);
    // refill the output register when empty or being taken
    assign pop = mem_has && (!o_valid || i_ready);
    assign o_empty = !mem_has && !o_valid;
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[AW-1:0]] <= i_data;
        if (pop) o_data <= r_mem[r_rp[AW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; o_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            if (pop) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire
